// ===== sv/bra_pkg.sv =====
// Shared constants and types of the bitmap run allocator.
`default_nettype none

package bra_pkg;

  // Size of the mark store in bytes, and the address width that follows from it.
  localparam int MAX_BYTES = 512;
  localparam int ADDR_W    = $clog2(MAX_BYTES);

  // Field widths of the request, the result and the length register.
  localparam int BLEN_W  = 10;
  localparam int IDX_W   = 12;
  localparam int RLEN_W  = 13;
  localparam int NBITS_W = BLEN_W + 3;

  localparam int BYTE_W = 8;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_TEST  = 2'd1,
    OP_SCAN  = 2'd2,
    OP_SET   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_ACCESS,
    ST_SCAN,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

// ===== sv/bra_if.sv =====
// Request and result channel interfaces of the bitmap run allocator.
`default_nettype none

interface bra_in_if ();
  logic                        valid;
  logic                        ready;
  logic [1:0]                  opcode;
  logic [bra_pkg::IDX_W-1:0]   bit_index;
  logic [bra_pkg::RLEN_W-1:0]  run_length;
  logic                        set_value;

  modport source (output valid, output opcode, output bit_index, output run_length,
                  output set_value, input ready);
  modport sink   (input valid, input opcode, input bit_index, input run_length,
                  input set_value, output ready);
endinterface

interface bra_out_if ();
  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic [bra_pkg::IDX_W-1:0]  start_index;
  logic                       bit_value;

  modport source (output valid, output ok, output start_index, output bit_value,
                  input ready);
  modport sink   (input valid, input ok, input start_index, input bit_value,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/bitmap_run_allocator_unit.sv =====
// Top level of the bitmap run allocator: mark store, request sequencer and result register.
`default_nettype none

// The allocator keeps one mark bit per allocation unit in a 512-byte store with one
// write and one read port (bit i lives in byte i/8 at position i%8, 1 = used) and serves
// one request at a time. After reset the block runs a clearing pass over all 512 bytes,
// during which no item is accepted; length register writes are taken at any time. A
// test or set item issues the byte read at acceptance, uses the read data (and writes
// back a set) in the access state and hands over the result in the response state. A
// clear writes one zero byte per cycle over byte_len bytes, where byte_len is clamped
// to 512. A scan walks the store one byte per cycle, since the memory gives one byte
// per read, and stops at the byte where the run is completed, or at the last byte in use.
// Requests out of range, zero-length scans and scans longer than the bits in use go
// straight to the response state. A finished result sits in the output register while
// the next item is accepted; the sequencer only waits if a second result is ready
// before the first one has been taken.

module bitmap_run_allocator_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  bra_in_if.sink                          in_ch,
  bra_out_if.source                       out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [bra_pkg::BLEN_W-1:0] cfg_wdata
);

  // Sequencer state and working registers.
  bra_pkg::state_t              state_r, state_nxt;
  logic [bra_pkg::ADDR_W-1:0]   count_r, count_nxt;
  logic [bra_pkg::RLEN_W-1:0]   run_r, run_nxt;

  // The request being served, captured at acceptance.
  bra_pkg::op_t                 op_r;
  logic [bra_pkg::IDX_W-1:0]    idx_r;
  logic [bra_pkg::RLEN_W-1:0]   len_r;
  logic                         val_r;

  // Result of the current request, waiting for the output register.
  logic                         res_ok_r, res_ok_nxt;
  logic [bra_pkg::IDX_W-1:0]    res_start_r, res_start_nxt;
  logic                         res_bit_r, res_bit_nxt;

  // Output register.
  logic                         out_valid_r;
  logic                         out_ok_r;
  logic [bra_pkg::IDX_W-1:0]    out_start_r;
  logic                         out_bit_r;
  logic                         out_free;
  logic                         out_load;

  // Number of store bytes in use, already clamped to the store size.
  logic [bra_pkg::BLEN_W-1:0]   nbytes_r;
  logic [bra_pkg::BLEN_W-1:0]   nbytes_m1;
  logic [bra_pkg::NBITS_W-1:0]  nbits;

  // Mark store with one write and one registered read port.
  logic [bra_pkg::BYTE_W-1:0]   mem [bra_pkg::MAX_BYTES];
  logic                         mem_we;
  logic [bra_pkg::ADDR_W-1:0]   mem_waddr;
  logic [bra_pkg::BYTE_W-1:0]   mem_wdata;
  logic [bra_pkg::ADDR_W-1:0]   mem_raddr;
  logic [bra_pkg::BYTE_W-1:0]   rd_data_r;

  // Input handshake.
  logic                         in_ready;
  logic                         in_take;
  bra_pkg::op_t                 in_op;

  // Per-byte scan step.
  logic [bra_pkg::RLEN_W-1:0]   run_v;
  logic                         found;
  logic [2:0]                   fpos;
  logic [bra_pkg::NBITS_W-1:0]  scan_start;

  assign nbytes_m1 = nbytes_r - 1'b1;
  assign nbits     = {nbytes_r, 3'b000};
  assign in_op     = bra_pkg::op_t'(in_ch.opcode);
  assign in_take   = in_ready && in_ch.valid;
  assign out_free  = !out_valid_r || out_ch.ready;

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.ok          = out_ok_r;
  assign out_ch.start_index = out_start_r;
  assign out_ch.bit_value   = out_bit_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // One byte of the scan: the run count carries over from the bytes before, and
  // the first bit at which the run reaches the wanted length ends the search.
  always_comb begin
    run_v = run_r;
    found = 1'b0;
    fpos  = 3'd0;
    for (int i = 0; i < bra_pkg::BYTE_W; i++) begin
      if (rd_data_r[i]) begin
        run_v = '0;
      end else begin
        run_v = run_v + 1'b1;
      end
      if (!found && run_v == len_r) begin
        found = 1'b1;
        fpos  = 3'(i);
      end
    end
  end

  // The run ends at the found bit, so its start lies len - 1 bits below.
  assign scan_start = {1'b0, count_r, fpos} + 1'b1 - len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bra_pkg::ST_INIT;
      count_r  <= '0;
      nbytes_r <= bra_pkg::BLEN_W'(bra_pkg::MAX_BYTES);
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_we) begin
        nbytes_r <= (cfg_wdata > bra_pkg::BLEN_W'(bra_pkg::MAX_BYTES)) ?
                    bra_pkg::BLEN_W'(bra_pkg::MAX_BYTES) : cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    run_r       <= run_nxt;
    res_ok_r    <= res_ok_nxt;
    res_start_r <= res_start_nxt;
    res_bit_r   <= res_bit_nxt;
    if (in_take) begin
      op_r  <= in_op;
      idx_r <= in_ch.bit_index;
      len_r <= in_ch.run_length;
      val_r <= in_ch.set_value;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    run_nxt       = run_r;
    res_ok_nxt    = res_ok_r;
    res_start_nxt = res_start_r;
    res_bit_nxt   = res_bit_r;
    mem_we        = 1'b0;
    mem_waddr     = count_r;
    mem_wdata     = '0;
    mem_raddr     = count_r + 1'b1;
    in_ready      = 1'b0;
    out_load      = 1'b0;

    case (state_r)
      bra_pkg::ST_INIT: begin
        mem_we = 1'b1;
        if (count_r == bra_pkg::ADDR_W'(bra_pkg::MAX_BYTES - 1)) begin
          count_nxt = '0;
          state_nxt = bra_pkg::ST_IDLE;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end

      bra_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        mem_raddr = (in_op == bra_pkg::OP_SCAN) ? '0 :
                    in_ch.bit_index[bra_pkg::IDX_W-1:3];
        if (in_ch.valid) begin
          count_nxt     = '0;
          run_nxt       = '0;
          res_ok_nxt    = 1'b0;
          res_start_nxt = '0;
          res_bit_nxt   = 1'b0;
          case (in_op)
            bra_pkg::OP_CLEAR: begin
              if (nbytes_r == '0) begin
                res_ok_nxt = 1'b1;
                state_nxt  = bra_pkg::ST_RESP;
              end else begin
                state_nxt = bra_pkg::ST_CLEAR;
              end
            end
            bra_pkg::OP_TEST, bra_pkg::OP_SET: begin
              if ({1'b0, in_ch.bit_index} < nbits) begin
                state_nxt = bra_pkg::ST_ACCESS;
              end else begin
                state_nxt = bra_pkg::ST_RESP;
              end
            end
            bra_pkg::OP_SCAN: begin
              if (in_ch.run_length != '0 && in_ch.run_length <= nbits) begin
                state_nxt = bra_pkg::ST_SCAN;
              end else begin
                state_nxt = bra_pkg::ST_RESP;
              end
            end
            default: begin
              state_nxt = bra_pkg::ST_RESP;
            end
          endcase
        end
      end

      bra_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        if ({1'b0, count_r} == nbytes_m1) begin
          res_ok_nxt = 1'b1;
          state_nxt  = bra_pkg::ST_RESP;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end

      bra_pkg::ST_ACCESS: begin
        res_ok_nxt = 1'b1;
        if (op_r == bra_pkg::OP_TEST) begin
          res_bit_nxt = rd_data_r[idx_r[2:0]];
        end else begin
          mem_we                = 1'b1;
          mem_waddr             = idx_r[bra_pkg::IDX_W-1:3];
          mem_wdata             = rd_data_r;
          mem_wdata[idx_r[2:0]] = val_r;
        end
        state_nxt = bra_pkg::ST_RESP;
      end

      bra_pkg::ST_SCAN: begin
        if (found) begin
          res_ok_nxt    = 1'b1;
          res_start_nxt = scan_start[bra_pkg::IDX_W-1:0];
          state_nxt     = bra_pkg::ST_RESP;
        end else if ({1'b0, count_r} == nbytes_m1) begin
          state_nxt = bra_pkg::ST_RESP;
        end else begin
          count_nxt = count_r + 1'b1;
          run_nxt   = run_v;
        end
      end

      bra_pkg::ST_RESP: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = bra_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = bra_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ok_r    <= res_ok_r;
      out_start_r <= res_start_r;
      out_bit_r   <= res_bit_r;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bra_checker.sv =====
// Port-level assertions for the bitmap run allocator and their binding.
`default_nettype none

module bra_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic                      out_ok,
  input wire logic [bra_pkg::IDX_W-1:0] out_start_index,
  input wire logic                      out_bit_value
);

  // The clearing pass after reset keeps the input closed.
  a_init_closed: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("item accepted during the clearing pass");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // A result waits until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A failed request carries no start position and no bit.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_ok |-> out_start_index == '0 && !out_bit_value)
    else $error("failed request with nonzero payload");

  // A set bit can only come from a test that was in range.
  a_bit_ok: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_bit_value |-> out_ok && out_start_index == '0)
    else $error("bit value on a failed or scan result");

endmodule

bind bitmap_run_allocator_unit bra_checker u_bra_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_ok          (out_ch.ok),
  .out_start_index (out_ch.start_index),
  .out_bit_value   (out_ch.bit_value)
);

`default_nettype wire
